FILE: rtl/core/fsp_pkg.sv
// fsp_pkg: types and constants for the format spec parser
// transaction structs for the input and result channels, character codes, phase codes
// no dependencies
package fsp_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       first;
  } fsp_in_t;

  typedef struct packed {
    logic        left_align;
    logic        center_align;
    logic        zero_pad;
    logic [15:0] field_width;
    logic        has_precision;
    logic [15:0] precision_value;
    logic        truncate;
    logic [15:0] repeat_count;
    logic [7:0]  specifier;
    logic        malformed;
  } fsp_out_t;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] PH_FLAGS  = 3'd0;
  localparam logic [2:0] PH_WIDTH  = 3'd1;
  localparam logic [2:0] PH_PREC   = 3'd2;
  localparam logic [2:0] PH_TRUNC  = 3'd3;
  localparam logic [2:0] PH_REPEAT = 3'd4;

  localparam int FB_LEFT   = 0;
  localparam int FB_CENTER = 1;
  localparam int FB_ZERO   = 2;

endpackage

FILE: rtl/core/format_spec_parser_unit.sv
// format_spec_parser_unit: top level of the format spec parser
// input register, fsp_core decode and result register; depends on fsp_pkg, fsp_core
//
//   channel  | ports                          | payload
//   input    | in_valid, in_ready, in_data    | fsp_in_t, one character per transaction
//   result   | out_valid, out_ready, out_data | fsp_out_t, zero or one per input transaction
//
// one character is accepted every cycle while no result stalls; the result is registered
// the only loop is the spec state update in fsp_core, one character per unstalled cycle
// reset is synchronous, active low, and clears both pipeline stages and the spec state
// a result held on a low out_ready stalls the pipeline; in_ready drops only then
module format_spec_parser_unit import fsp_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fsp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output fsp_out_t out_data
);

  logic     in_valid_r;
  fsp_in_t  in_data_r;
  logic     out_valid_r;
  fsp_out_t out_data_r;
  logic     stall;
  logic     advance;
  logic     res_valid;
  fsp_out_t res;

  assign stall   = out_valid_r & ~out_ready;
  assign advance = in_valid_r & ~stall;
  assign in_ready = ~in_valid_r | ~stall;

  fsp_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (advance),
    .item     (in_data_r),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!stall) begin
      out_valid_r <= advance & res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/fsp_core.sv
// fsp_core: spec parser state and per-character decode
// holds the partial spec, steps it by one character and forms the result
// depends on fsp_pkg
module fsp_core import fsp_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  fsp_in_t  item,
  output logic     res_valid,
  output fsp_out_t res
);

  localparam int CB = COUNT_BITS;

  logic [2:0]    phase_r, phase_nxt;
  logic [2:0]    flag_r, flag_nxt;
  logic [CB-1:0] width_r, width_nxt;
  logic [CB-1:0] prec_r, prec_nxt;
  logic          prec_seen_r, prec_seen_nxt;
  logic          trunc_r, trunc_nxt;
  logic [CB-1:0] repeat_r, repeat_nxt;

  logic [2:0]    ph;
  logic [2:0]    flg;
  logic [CB-1:0] wacc, pacc, racc, rep;
  logic          pseen, tseen;
  logic [7:0]    c;
  logic          is_dig;
  logic          emit;
  logic          eff_left, eff_center, eff_zero;

  function automatic logic [CB-1:0] acc_push(input logic [CB-1:0] acc, input logic [3:0] d);
    logic [CB+3:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (CB+4)'(d);
    return (v[CB+3:CB] != 4'b0) ? {CB{1'b1}} : v[CB-1:0];
  endfunction

  always_comb begin
    c      = item.char_in;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    ph     = item.first ? PH_FLAGS : phase_r;
    flg    = item.first ? 3'b0 : flag_r;
    wacc   = item.first ? '0 : width_r;
    pacc   = item.first ? '0 : prec_r;
    racc   = item.first ? '0 : repeat_r;
    pseen  = item.first ? 1'b0 : prec_seen_r;
    tseen  = item.first ? 1'b0 : trunc_r;

    phase_nxt     = ph;
    flag_nxt      = flg;
    width_nxt     = wacc;
    prec_nxt      = pacc;
    prec_seen_nxt = pseen;
    trunc_nxt     = tseen;
    repeat_nxt    = racc;
    emit          = 1'b0;

    priority if (ph == PH_FLAGS && c == CH_MINUS) begin
      flag_nxt[FB_LEFT] = 1'b1;
    end else if (ph == PH_FLAGS && c == CH_UNDER) begin
      flag_nxt[FB_CENTER] = 1'b1;
    end else if (ph == PH_FLAGS && c == CH_ZERO) begin
      flag_nxt[FB_ZERO] = 1'b1;
    end else if (ph <= PH_WIDTH && is_dig) begin
      width_nxt = acc_push(wacc, c[3:0]);
      phase_nxt = PH_WIDTH;
    end else if (ph <= PH_WIDTH && c == CH_DOT) begin
      prec_seen_nxt = 1'b1;
      phase_nxt     = PH_PREC;
    end else if (ph == PH_PREC && is_dig) begin
      prec_nxt = acc_push(pacc, c[3:0]);
    end else if (ph <= PH_PREC && c == CH_BANG) begin
      trunc_nxt = 1'b1;
      phase_nxt = PH_TRUNC;
    end else if (ph <= PH_TRUNC && c == CH_STAR) begin
      phase_nxt = PH_REPEAT;
    end else if (ph <= PH_TRUNC) begin
      emit = 1'b1;
    end else if (ph == PH_REPEAT && is_dig) begin
      repeat_nxt = acc_push(racc, c[3:0]);
    end else if (ph == PH_REPEAT) begin
      emit = 1'b1;
    end else begin
      phase_nxt     = PH_FLAGS;
      flag_nxt      = 3'b0;
      width_nxt     = '0;
      prec_nxt      = '0;
      prec_seen_nxt = 1'b0;
      trunc_nxt     = 1'b0;
      repeat_nxt    = '0;
    end

    if (emit) begin
      phase_nxt     = PH_FLAGS;
      flag_nxt      = 3'b0;
      width_nxt     = '0;
      prec_nxt      = '0;
      prec_seen_nxt = 1'b0;
      trunc_nxt     = 1'b0;
      repeat_nxt    = '0;
    end
  end

  // result fields from the spec as it stood before this character
  always_comb begin
    eff_center = flg[FB_CENTER];
    eff_left   = flg[FB_LEFT] & ~eff_center;
    eff_zero   = flg[FB_ZERO] & ~flg[FB_LEFT] & ~eff_center;
    rep        = (racc == '0) ? CB'(1) : racc;
    res_valid  = emit;
    if (c == CH_NUL) begin
      res                 = '0;
      res.repeat_count    = 16'd1;
      res.malformed       = 1'b1;
    end else begin
      res.left_align      = eff_left;
      res.center_align    = eff_center;
      res.zero_pad        = eff_zero;
      res.field_width     = 16'(wacc);
      res.has_precision   = pseen;
      res.precision_value = 16'(pacc);
      res.truncate        = tseen;
      res.repeat_count    = 16'(rep);
      res.specifier       = c;
      res.malformed       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FLAGS;
      flag_r      <= 3'b0;
      width_r     <= '0;
      prec_r      <= '0;
      prec_seen_r <= 1'b0;
      trunc_r     <= 1'b0;
      repeat_r    <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      flag_r      <= flag_nxt;
      width_r     <= width_nxt;
      prec_r      <= prec_nxt;
      prec_seen_r <= prec_seen_nxt;
      trunc_r     <= trunc_nxt;
      repeat_r    <= repeat_nxt;
    end
  end

endmodule

FILE: rtl/core/fsp_checker.sv
// fsp_checker: port-level assertions for format_spec_parser_unit
// bound to the top level below; depends on fsp_pkg
module fsp_checker import fsp_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input fsp_out_t out_data
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_malformed_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.malformed |->
      out_data.specifier == 8'h00 && out_data.repeat_count == 16'd1 &&
      out_data.field_width == 16'd0 && !out_data.has_precision)
    else $error("malformed result carries spec fields");

  a_specifier_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.malformed |-> out_data.specifier != 8'h00)
    else $error("well-formed result with nul specifier");

  a_align_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_data.left_align, out_data.center_align,
                              out_data.zero_pad}) <= 1)
    else $error("alignment flags not normalized");

  // the input is refused only while a stalled result waits
  a_ready_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

endmodule

bind format_spec_parser_unit fsp_checker u_fsp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

FILE: tb/format_spec_parser_unit_tb.sv
// format_spec_parser_unit_tb: self-checking testbench for the format spec parser
// directed table with typed results, then random spec streams checked by an in-bench spec parser
// depends on fsp_pkg and format_spec_parser_unit
module format_spec_parser_unit_tb;
  import fsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_BITS = 16;
  localparam longint COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int ITEMS_PER_PHASE = 170;

  typedef struct {
    fsp_in_t  stim;
    bit       typed;
    fsp_out_t res;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  fsp_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  fsp_out_t out_data;

  format_spec_parser_unit #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // spec state of the in-bench parser
  logic [2:0] sp_phase;
  logic [2:0] sp_flags;
  longint     sp_width;
  longint     sp_prec;
  longint     sp_rep;
  bit         sp_prec_seen;
  bit         sp_trunc;

  fsp_out_t   pending_specs[$];
  dir_row_t   dir_tab[$];
  logic [7:0] spec_chars[$];
  int         err_cnt = 0;
  int         cycle_cnt = 0;
  int         n_sent = 0;
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;
  bit         cur_typed = 1'b0;
  fsp_out_t   cur_res = '0;

  function automatic fsp_out_t mk_res(input logic l, input logic c, input logic z,
                                      input logic [15:0] w, input logic hp,
                                      input logic [15:0] p, input logic t,
                                      input logic [15:0] r, input logic [7:0] s,
                                      input logic m);
    fsp_out_t o;
    o.left_align      = l;
    o.center_align    = c;
    o.zero_pad        = z;
    o.field_width     = w;
    o.has_precision   = hp;
    o.precision_value = p;
    o.truncate        = t;
    o.repeat_count    = r;
    o.specifier       = s;
    o.malformed       = m;
    return o;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic longint push_digit(input longint acc, input logic [7:0] c);
    longint v;
    v = acc * 10 + (longint'(c) - longint'(CH_ZERO));
    return (v > COUNT_MAX) ? COUNT_MAX : v;
  endfunction

  task automatic clear_spec();
    sp_phase     = PH_FLAGS;
    sp_flags     = '0;
    sp_width     = 0;
    sp_prec      = 0;
    sp_rep       = 0;
    sp_prec_seen = 1'b0;
    sp_trunc     = 1'b0;
  endtask

  task automatic close_spec(input logic [7:0] c, output fsp_out_t r);
    logic l, ctr, z;
    r = '0;
    if (c == CH_NUL) begin
      r.repeat_count = 16'd1;
      r.malformed    = 1'b1;
    end else begin
      ctr = sp_flags[FB_CENTER];
      l   = sp_flags[FB_LEFT] && !ctr;
      z   = sp_flags[FB_ZERO] && !sp_flags[FB_LEFT] && !ctr;
      r = mk_res(l, ctr, z, sp_width[15:0], sp_prec_seen, sp_prec[15:0], sp_trunc,
                 (sp_rep == 0) ? 16'd1 : sp_rep[15:0], c, 1'b0);
    end
    clear_spec();
  endtask

  task automatic parse_char(input fsp_in_t d, output bit got, output fsp_out_t r);
    logic [7:0] c;
    bit done;
    c    = d.char_in;
    got  = 1'b0;
    done = 1'b0;
    r    = '0;
    if (d.first) clear_spec();
    if (sp_phase == PH_FLAGS) begin
      if (c == CH_MINUS) begin
        sp_flags[FB_LEFT] = 1'b1;
        done = 1'b1;
      end else if (c == CH_UNDER) begin
        sp_flags[FB_CENTER] = 1'b1;
        done = 1'b1;
      end else if (c == CH_ZERO) begin
        sp_flags[FB_ZERO] = 1'b1;
        done = 1'b1;
      end
    end
    if (!done && (sp_phase == PH_FLAGS || sp_phase == PH_WIDTH)) begin
      if (is_digit(c)) begin
        sp_width = push_digit(sp_width, c);
        sp_phase = PH_WIDTH;
        done = 1'b1;
      end else if (c == CH_DOT) begin
        sp_prec_seen = 1'b1;
        sp_phase = PH_PREC;
        done = 1'b1;
      end
    end
    if (!done && sp_phase <= PH_PREC) begin
      if (sp_phase == PH_PREC && is_digit(c)) begin
        sp_prec = push_digit(sp_prec, c);
        done = 1'b1;
      end else if (c == CH_BANG) begin
        sp_trunc = 1'b1;
        sp_phase = PH_TRUNC;
        done = 1'b1;
      end
    end
    if (!done && sp_phase <= PH_TRUNC) begin
      if (c == CH_STAR) begin
        sp_phase = PH_REPEAT;
      end else begin
        close_spec(c, r);
        got = 1'b1;
      end
      done = 1'b1;
    end
    if (!done && sp_phase == PH_REPEAT) begin
      if (is_digit(c)) begin
        sp_rep = push_digit(sp_rep, c);
      end else begin
        close_spec(c, r);
        got = 1'b1;
      end
      done = 1'b1;
    end
    if (!done) clear_spec();
  endtask

  task automatic cmp_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  task automatic check_spec(input fsp_out_t e, input fsp_out_t a);
    cmp_field("left_align", e.left_align, a.left_align);
    cmp_field("center_align", e.center_align, a.center_align);
    cmp_field("zero_pad", e.zero_pad, a.zero_pad);
    cmp_field("field_width", e.field_width, a.field_width);
    cmp_field("has_precision", e.has_precision, a.has_precision);
    cmp_field("precision_value", e.precision_value, a.precision_value);
    cmp_field("truncate", e.truncate, a.truncate);
    cmp_field("repeat_count", e.repeat_count, a.repeat_count);
    cmp_field("specifier", e.specifier, a.specifier);
    cmp_field("malformed", e.malformed, a.malformed);
  endtask

  always @(posedge clk) begin : watch
    bit got;
    fsp_out_t r;
    if (rst_n && in_valid && in_ready) begin
      parse_char(in_data, got, r);
      if (cur_typed) pending_specs.push_back(cur_res);
      else if (got) pending_specs.push_back(r);
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_specs.size() == 0) begin
        $error("unexpected result, specifier %0h", out_data.specifier);
        err_cnt++;
      end else begin
        check_spec(pending_specs.pop_front(), out_data);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic send_char(input fsp_in_t d, input bit typed, input fsp_out_t res);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cur_typed = typed;
    cur_res   = res;
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_specs.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(input logic [7:0] c, input logic f, input bit typed,
                         input fsp_out_t res);
    dir_row_t row;
    row.stim.char_in = c;
    row.stim.first   = f;
    row.typed        = typed;
    row.res          = res;
    dir_tab.push_back(row);
  endtask

  function automatic void add_digits();
    int n;
    n = ($urandom_range(7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
    repeat (n) spec_chars.push_back(CH_ZERO + 8'($urandom_range(9)));
  endfunction

  task automatic send_random_spec();
    int n;
    fsp_in_t d;
    spec_chars.delete();
    if ($urandom_range(15) == 0) begin
      // noise
      n = $urandom_range(1, 6);
      repeat (n) spec_chars.push_back(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(3);
      repeat (n) begin
        case ($urandom_range(2))
          0: spec_chars.push_back(CH_MINUS);
          1: spec_chars.push_back(CH_UNDER);
          default: spec_chars.push_back(CH_ZERO);
        endcase
      end
      if ($urandom_range(1)) add_digits();
      if ($urandom_range(1)) begin
        spec_chars.push_back(CH_DOT);
        if ($urandom_range(3) != 0) add_digits();
      end
      if ($urandom_range(3) == 0) spec_chars.push_back(CH_BANG);
      if ($urandom_range(2) == 0) begin
        spec_chars.push_back(CH_STAR);
        if ($urandom_range(1)) add_digits();
      end
      case ($urandom_range(11))
        0: spec_chars.push_back(CH_NUL);
        1, 2: spec_chars.push_back(8'($urandom_range(255)));
        3: begin
          case ($urandom_range(3))
            0: spec_chars.push_back(CH_DOT);
            1: spec_chars.push_back(CH_BANG);
            2: spec_chars.push_back(CH_STAR);
            default: spec_chars.push_back(CH_ZERO + 8'($urandom_range(9)));
          endcase
        end
        4: begin
          // broken spec, cut short
          n = $urandom_range(spec_chars.size());
          while (spec_chars.size() > n) void'(spec_chars.pop_back());
        end
        default: spec_chars.push_back("a" + 8'($urandom_range(25)));
      endcase
    end
    foreach (spec_chars[i]) begin
      d.char_in = spec_chars[i];
      d.first   = (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(39) == 0);
      send_char(d, 1'b0, '0);
    end
  endtask

  initial begin
    int limit;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    clear_spec();

    add_row(8'hFF, 1'b1, 1'b1, mk_res(1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0,
                                      16'd1, 8'hFF, 1'b0));
    add_row(CH_NUL, 1'b0, 1'b1, mk_res(1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0,
                                       16'd1, CH_NUL, 1'b1));
    add_row(CH_MINUS, 1'b0, 1'b0, '0);
    add_row(CH_ZERO, 1'b0, 1'b0, '0);
    add_row(CH_ZERO + 8'd1, 1'b0, 1'b0, '0);
    add_row(CH_ZERO, 1'b0, 1'b0, '0);
    add_row(CH_DOT, 1'b0, 1'b0, '0);
    add_row(CH_ZERO + 8'd3, 1'b0, 1'b0, '0);
    add_row(CH_BANG, 1'b0, 1'b0, '0);
    add_row(CH_STAR, 1'b0, 1'b0, '0);
    add_row(CH_ZERO + 8'd2, 1'b0, 1'b0, '0);
    add_row("s", 1'b0, 1'b1, mk_res(1'b1, 1'b0, 1'b0, 16'd10, 1'b1, 16'd3, 1'b1,
                                    16'd2, "s", 1'b0));
    add_row(CH_UNDER, 1'b0, 1'b0, '0);
    add_row(CH_MINUS, 1'b0, 1'b0, '0);
    add_row(CH_ZERO, 1'b0, 1'b0, '0);
    add_row("x", 1'b0, 1'b1, mk_res(1'b0, 1'b1, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0,
                                    16'd1, "x", 1'b0));
    // width saturates, repeat of zero, late bang as specifier
    repeat (5) add_row(CH_NINE, 1'b0, 1'b0, '0);
    add_row(CH_DOT, 1'b0, 1'b0, '0);
    add_row(CH_STAR, 1'b0, 1'b0, '0);
    add_row(CH_ZERO, 1'b0, 1'b0, '0);
    add_row(CH_BANG, 1'b0, 1'b1, mk_res(1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b1, 16'd0, 1'b0,
                                        16'd1, CH_BANG, 1'b0));
    add_row(CH_MINUS, 1'b0, 1'b0, '0);
    add_row("c", 1'b1, 1'b1, mk_res(1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0,
                                    16'd1, "c", 1'b0));

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) send_char(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].res);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 11; rcv_idle_pct = 88; end
        1: begin snd_idle_pct = 88; rcv_idle_pct = 11; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      limit = n_sent + ITEMS_PER_PHASE;
      while (n_sent < limit) begin
        send_random_spec();
        if (ph == 2 && !hold_done && n_sent >= limit - ITEMS_PER_PHASE / 2) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
      end
      drain();
    end

    repeat (10) @(negedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/fsp_pkg.sv
rtl/core/fsp_core.sv
rtl/core/format_spec_parser_unit.sv
rtl/core/fsp_checker.sv
tb/format_spec_parser_unit_tb.sv
